/* rtl/core/flptm_pkg.sv */
package flptm_pkg;

    // Pool geometry.
    localparam int POOL_PAGES = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int ADDR_W = PAGE_W + IDX_W;
    localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
    localparam int NFP_W = $clog2(POOL_PAGES + 1);

    // Field widths.
    localparam int VPAGE_W = 36;
    localparam int FRAME_W = 40;
    localparam int FRAME_LSB = 12;
    localparam int ENTRY_W = 64;
    localparam int RPAGE_W = 6;
    localparam int USED_W = 7;

    // Entry layout.
    localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h1;
    localparam logic [ENTRY_W-1:0] BIT_RW = 64'h2;
    localparam logic [ENTRY_W-1:0] BIT_USER = 64'h4;
    localparam logic [ENTRY_W-1:0] FRAME_FIELD = {12'h000, {FRAME_W{1'b1}}, 12'h000};

    // Request kinds and status codes.
    localparam logic KIND_MAP = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [VPAGE_W-1:0] virt_page;
        logic [FRAME_W-1:0] phys_frame;
        logic [RPAGE_W-1:0] read_page;
        logic [IDX_W-1:0]   read_slot;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] read_data;
        logic [USED_W-1:0]  pages_used;
        logic               status;
    } rsp_t;

    // A stored word carries the allocation mark of its page at write time.
    typedef struct packed {
        logic               tag;
        logic [ENTRY_W-1:0] data;
    } store_word_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        store_word_t       wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_READ,
        ST_RDATA
    } state_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [VPAGE_W-1:0] vp,
                                                    input logic [1:0] lvl);
        return IDX_W'(vp >> (IDX_W * int'(lvl)));
    endfunction

endpackage

/* rtl/core/flptm_store.sv */
module flptm_store (
    input  logic                   clk,
    input  flptm_pkg::mem_req_t    mem_req,
    output flptm_pkg::store_word_t mem_rdata
);
    import flptm_pkg::*;

    store_word_t mem [DEPTH];
    store_word_t rdata_reg;

    // Single port; read data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.addr];
    end

    assign mem_rdata = rdata_reg;

endmodule

/* rtl/core/flptm_walk.sv */
module flptm_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  flptm_pkg::req_t                req,
    input  logic [flptm_pkg::FRAME_W-1:0]  base_frame,
    output logic                           busy,
    output logic                           done,
    output flptm_pkg::rsp_t                rsp,
    output flptm_pkg::mem_req_t            mem_req,
    input  flptm_pkg::store_word_t         mem_rdata
);
    import flptm_pkg::*;

    state_t state_reg, state_next;
    req_t item_reg;
    logic [PAGE_W-1:0] cur_reg;
    logic [1:0] lvl_reg;
    logic [NFP_W-1:0] nfp_reg;
    logic [POOL_PAGES-1:0] alloc_reg;
    rsp_t rsp_reg, rsp_next;
    logic done_reg;
    logic finish_c;

    logic [IDX_W-1:0] idx_c;
    logic [ENTRY_W-1:0] entry_c;
    logic present_c, pool_full_c, leaf_c, take_c, tag_after_c, off_ok_c;
    logic [PAGE_W-1:0] new_page_c, rd_page_c;
    logic [FRAME_W-1:0] new_frame_c, off_c;
    logic [ENTRY_W-1:0] leaf_word_c, link_word_c;
    logic rd_ok_c;

    // Decode of the entry just read.
    always_comb
    begin
        idx_c = level_index(item_reg.virt_page, lvl_reg);
        entry_c = (mem_rdata.tag == alloc_reg[cur_reg]) ? mem_rdata.data : '0;
        present_c = entry_c[0];
        leaf_c = (lvl_reg == 2'd0);
        pool_full_c = (nfp_reg >= NFP_W'(POOL_PAGES));
        new_page_c = nfp_reg[PAGE_W-1:0];
        new_frame_c = base_frame + FRAME_W'(new_page_c);
        off_c = entry_c[FRAME_LSB +: FRAME_W] - base_frame;
        off_ok_c = (off_c < FRAME_W'(POOL_PAGES));
        take_c = (state_reg == ST_CHECK) && !leaf_c && !present_c && !pool_full_c;
        // A link written into the page being taken survives its clearing.
        tag_after_c = alloc_reg[cur_reg] | (take_c && (cur_reg == new_page_c));
        leaf_word_c = (entry_c & ~(FRAME_FIELD | BIT_USER))
                    | (ENTRY_W'(item_reg.phys_frame) << FRAME_LSB)
                    | BIT_PRESENT | BIT_RW;
        link_word_c = (entry_c & ~FRAME_FIELD)
                    | (ENTRY_W'(new_frame_c) << FRAME_LSB)
                    | BIT_PRESENT | BIT_RW;
        rd_page_c = PAGE_W'(item_reg.read_page);
        rd_ok_c = (32'(item_reg.read_page) < 32'(POOL_PAGES))
               && (mem_rdata.tag == alloc_reg[rd_page_c]);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.kind == KIND_READ) ? ST_READ : ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK:  state_next = finish_c ? ST_IDLE : ST_LOOKUP;
            ST_READ:   state_next = ST_RDATA;
            ST_RDATA:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory port, completion and result.
    always_comb
    begin
        mem_req.we = 1'b0;
        mem_req.addr = {cur_reg, idx_c};
        mem_req.wdata.tag = tag_after_c;
        mem_req.wdata.data = leaf_c ? leaf_word_c : link_word_c;
        finish_c = 1'b0;
        rsp_next.read_data = '0;
        rsp_next.pages_used = USED_W'(nfp_reg);
        rsp_next.status = STATUS_OK;
        unique case (state_reg)
            ST_IDLE, ST_LOOKUP:
            begin
            end
            ST_CHECK:
            begin
                mem_req.we = leaf_c || take_c;
                if (leaf_c)
                begin
                    finish_c = 1'b1;
                end
                else if ((!present_c && pool_full_c) || (present_c && !off_ok_c))
                begin
                    finish_c = 1'b1;
                    rsp_next.status = STATUS_FAIL;
                end
            end
            ST_READ:
            begin
                mem_req.addr = {rd_page_c, item_reg.read_slot};
            end
            ST_RDATA:
            begin
                finish_c = 1'b1;
                rsp_next.read_data = rd_ok_c ? mem_rdata.data : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg <= '0;
            lvl_reg <= '0;
            nfp_reg <= NFP_W'(1);
            alloc_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= finish_c;
            if (state_reg == ST_IDLE && start)
            begin
                cur_reg <= '0;
                lvl_reg <= 2'd3;
            end
            else if (take_c)
            begin
                alloc_reg[new_page_c] <= 1'b1;
                nfp_reg <= nfp_reg + NFP_W'(1);
                cur_reg <= new_page_c;
                lvl_reg <= lvl_reg - 2'd1;
            end
            else if (state_reg == ST_CHECK && !leaf_c && present_c && off_ok_c)
            begin
                cur_reg <= off_c[PAGE_W-1:0];
                lvl_reg <= lvl_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            item_reg <= req;
        end
        if (finish_c)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp = rsp_reg;

endmodule

/* rtl/core/four_level_page_table_mapper_core.sv */
// Map request: a lookup and a check for each of four levels through the registered table
// memory, ending early when the walk fails; read request: one table read and its data.
// One request at a time: busy drops with done.
// After reset a clearing pass writes every table entry, DEPTH entries (32768 at 64 pool
// pages); busy is high during it and configuration writes are taken as usual.
// The receiver cannot stall: done marks each result for exactly one cycle.
module four_level_page_table_mapper_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  flptm_pkg::req_t               req,
    output logic                          done,
    output flptm_pkg::rsp_t               rsp,
    input  logic                          cfg_we,
    input  logic [flptm_pkg::FRAME_W-1:0] cfg_data
);
    import flptm_pkg::*;

    // Frame number of pool page 0, the root table.
    logic [FRAME_W-1:0] base_reg;

    // Clearing pass state: the memory holds garbage at power-up.
    logic clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic walk_busy;
    mem_req_t walk_mem_req, mem_req;
    store_word_t mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    // Sweep the whole store once, one entry per cycle, writing zero with a clear tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // The sweep owns the memory port until it finishes; the walker is idle then.
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_req.we = 1'b1;
            mem_req.addr = clr_addr_reg;
            mem_req.wdata = '0;
        end
        else
        begin
            mem_req = walk_mem_req;
        end
    end

    flptm_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start & ~clearing_reg),
        .req        (req),
        .base_frame (base_reg),
        .busy       (walk_busy),
        .done       (done),
        .rsp        (rsp),
        .mem_req    (walk_mem_req),
        .mem_rdata  (mem_rdata)
    );

    flptm_store u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign busy = clearing_reg | walk_busy;

endmodule

/* sim/four_level_page_table_mapper_checker.sv */
`timescale 1ns / 1ps

module four_level_page_table_mapper_checker
    import flptm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  req_t               req,
    input  logic               done,
    input  rsp_t               rsp,
    input  logic               cfg_we,
    input  logic [FRAME_W-1:0] cfg_data,
    input  logic               end_of_run,
    output int                 mismatch_count
);

    localparam int MAX_PRINTED = 50;

    // Shadow copy of the table pool and the allocator.
    logic [ENTRY_W-1:0] table_words [DEPTH];
    logic [FRAME_W-1:0] pool_base;
    int                 pages_taken;
    rsp_t               pending_results [$];

    initial mismatch_count = 0;

    // Printing stops after the first few dozen lines; the count goes on.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Applies one request to the shadow tables and returns the response it must produce.
    function automatic rsp_t predict_result(input req_t r);
        rsp_t               res;
        logic [ENTRY_W-1:0] entry;
        logic [FRAME_W-1:0] offset;
        logic [IDX_W-1:0]   slot;
        int                 page;
        int                 new_page;
        int                 lvl;
        int                 k;
        bit                 walking;
        res = '0;
        res.status = STATUS_OK;
        if (r.kind == KIND_MAP)
        begin
            page = 0;
            walking = 1'b1;
            for (lvl = 3; lvl >= 1; lvl--)
            begin
                if (walking)
                begin
                    slot = r.virt_page[IDX_W*lvl +: IDX_W];
                    entry = table_words[page*ENTRIES_PER_TABLE + slot];
                    if ((entry & BIT_PRESENT) == '0)
                    begin
                        if (pages_taken >= POOL_PAGES)
                        begin
                            walking = 1'b0;
                        end
                        else
                        begin
                            new_page = pages_taken;
                            pages_taken++;
                            for (k = 0; k < ENTRIES_PER_TABLE; k++)
                            begin
                                table_words[new_page*ENTRIES_PER_TABLE + k] = '0;
                            end
                            entry[FRAME_LSB +: FRAME_W] = pool_base + FRAME_W'(new_page);
                            entry = entry | BIT_PRESENT | BIT_RW;
                            table_words[page*ENTRIES_PER_TABLE + slot] = entry;
                            page = new_page;
                        end
                    end
                    else
                    begin
                        // A frame that does not land inside the pool ends the walk.
                        offset = entry[FRAME_LSB +: FRAME_W] - pool_base;
                        if (offset >= POOL_PAGES)
                        begin
                            walking = 1'b0;
                        end
                        else
                        begin
                            page = int'(offset);
                        end
                    end
                end
            end
            if (walking)
            begin
                slot = r.virt_page[IDX_W-1:0];
                entry = table_words[page*ENTRIES_PER_TABLE + slot];
                entry = entry & ~(FRAME_FIELD | BIT_USER);
                entry[FRAME_LSB +: FRAME_W] = r.phys_frame;
                entry = entry | BIT_PRESENT | BIT_RW;
                table_words[page*ENTRIES_PER_TABLE + slot] = entry;
            end
            else
            begin
                res.status = STATUS_FAIL;
            end
        end
        else if (int'(r.read_page) < POOL_PAGES)
        begin
            res.read_data = table_words[int'(r.read_page)*ENTRIES_PER_TABLE + r.read_slot];
        end
        res.pages_used = USED_W'(pages_taken);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                table_words[k] = '0;
            end
            pool_base = '0;
            pages_taken = 1;
            pending_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("response with no request pending: data=%h used=%0d st=%b",
                                              rsp.read_data, rsp.pages_used, rsp.status));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  rsp.read_data, want.read_data));
                    end
                    if (rsp.pages_used !== want.pages_used)
                    begin
                        report_mismatch($sformatf("pages_used %0d, expected %0d",
                                                  rsp.pages_used, want.pages_used));
                    end
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch($sformatf("status %b, expected %b",
                                                  rsp.status, want.status));
                    end
                end
            end
            if (cfg_we)
            begin
                pool_base = cfg_data;
            end
            if (start && !busy)
            begin
                pending_results.push_back(predict_result(req));
            end
        end
    end

    always @(posedge end_of_run)
    begin
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
        end
    end

endmodule

/* sim/four_level_page_table_mapper_core_tb.sv */
`timescale 1ns / 1ps

module four_level_page_table_mapper_core_tb;

    import flptm_pkg::*;

    // The longest quiet stretch of a correct run is the clearing pass after reset
    // (one cycle per table entry); the watchdog allows several times that.
    localparam int QUIET_LIMIT = 150000;
    // This is the tail waited out at the very end.
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REMEMBERED = 128;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    req_t               req = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_we = 1'b0;
    logic [FRAME_W-1:0] cfg_data = '0;
    logic               end_of_run = 1'b0;
    int                 mismatch_count;

    // Bookkeeping for the stimulus side only: requests issued, responses seen,
    // and the virtual pages mapped so far, which later requests reuse so that
    // walks go through tables that already exist.
    int                 sent_count = 0;
    int                 done_count = 0;
    int                 quiet_cycles = 0;
    int                 pages_seen = 1;
    logic [VPAGE_W-1:0] mapped_pages [$];

    always #4 clk = ~clk;

    four_level_page_table_mapper_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    four_level_page_table_mapper_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .end_of_run     (end_of_run),
        .mismatch_count (mismatch_count)
    );

    // The pool fill level reported by the block steers read requests toward pages
    // that actually hold tables.
    always @(posedge clk)
    begin
        if (done)
        begin
            done_count <= done_count + 1;
            pages_seen <= (rsp.pages_used == 0) ? 1 : int'(rsp.pages_used);
        end
    end

    // Watchdog: ends the run when neither a request nor a response moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request and holds it until the block takes it, which happens at
    // the first rising edge that sees start high and busy low.
    task automatic issue(input req_t r);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent_count++;
        if (r.kind == KIND_MAP)
        begin
            if (mapped_pages.size() < MAX_REMEMBERED)
            begin
                mapped_pages.push_back(r.virt_page);
            end
            else
            begin
                mapped_pages[$urandom_range(0, MAX_REMEMBERED - 1)] = r.virt_page;
            end
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // The block is idle once every issued request has been answered and busy is low.
    task automatic wait_idle();
        start <= 1'b0;
        while (done_count != sent_count || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_pool_base(input logic [FRAME_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic req_t map_request(input logic [VPAGE_W-1:0] vp,
                                         input logic [FRAME_W-1:0] frame);
        req_t r;
        r = '0;
        r.kind = KIND_MAP;
        r.virt_page = vp;
        r.phys_frame = frame;
        return r;
    endfunction

    function automatic req_t read_request(input int page, input int slot);
        req_t r;
        r = '0;
        r.kind = KIND_READ;
        r.read_page = RPAGE_W'(page);
        r.read_slot = IDX_W'(slot);
        return r;
    endfunction

    // Random traffic in bursts. Most map requests reuse the upper indices of a page
    // mapped earlier, so that walks reach the leaf level even after the pool has run
    // out; the rest share only the top one or two levels or are fully random, which
    // drives allocations and pool exhaustion. Reads mostly aim at allocated pages and
    // at slots that earlier maps used; the rest read anywhere, unused pages included.
    task automatic run_random_phase(input int count);
        req_t               r;
        logic [VPAGE_W-1:0] known;
        int                 choice;
        int                 burst_left;
        int                 gap;
        int                 lvl;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++)
        begin
            r.virt_page = VPAGE_W'({$urandom, $urandom});
            r.phys_frame = FRAME_W'({$urandom, $urandom});
            r.read_page = RPAGE_W'($urandom);
            r.read_slot = IDX_W'($urandom);
            known = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
            choice = $urandom_range(0, 99);
            if (choice < 8)
            begin
                // Remap an existing leaf with a new frame.
                r.kind = KIND_MAP;
                r.virt_page = known;
            end
            else if (choice < 35)
            begin
                r.kind = KIND_MAP;
                r.virt_page[VPAGE_W-1:IDX_W] = known[VPAGE_W-1:IDX_W];
            end
            else if (choice < 45)
            begin
                r.kind = KIND_MAP;
                r.virt_page[VPAGE_W-1:VPAGE_W-IDX_W] = known[VPAGE_W-1:VPAGE_W-IDX_W];
                if ($urandom_range(0, 1) == 1)
                begin
                    r.virt_page[VPAGE_W-1:2*IDX_W] = known[VPAGE_W-1:2*IDX_W];
                end
            end
            else if (choice < 55)
            begin
                r.kind = KIND_MAP;
            end
            else
            begin
                r.kind = KIND_READ;
                if (choice < 82)
                begin
                    lvl = $urandom_range(0, 3);
                    r.read_page = RPAGE_W'($urandom_range(0, pages_seen - 1));
                    r.read_slot = known[IDX_W*lvl +: IDX_W];
                end
            end
            issue(r);
            burst_left--;
            if (burst_left == 0)
            begin
                // A quarter of the bursts run straight into the next one.
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                pause_sender(gap);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The block accepts the register while it clears its tables; requests wait
        // behind busy until the clearing pass is over.
        write_pool_base('0);

        // A page that was never taken reads as zero.
        issue(read_request(POOL_PAGES - 1, ENTRIES_PER_TABLE - 1));
        // Lowest and highest virtual page, each with a full fresh walk.
        issue(map_request('0, '0));
        issue(map_request('1, '1));
        issue(read_request(0, 0));
        issue(read_request(3, 0));
        // Remapping an existing page only rewrites the leaf.
        issue(map_request('0, 40'hA5_A5A5_A5A5));
        issue(read_request(3, 0));
        // Shares the root entry with page zero and allocates the two levels below it.
        issue(map_request({9'h000, 9'h1ff, 9'h000, 9'h005}, FRAME_W'({$urandom, $urandom})));
        // Distinct root slots use up the pool; the last map runs dry halfway down,
        // keeping the table it already allocated.
        for (int k = 1; k <= 19; k++)
        begin
            issue(map_request({IDX_W'(k), 27'($urandom)}, FRAME_W'({$urandom, $urandom})));
        end

        // Pool base at zero, as the tables were built.
        run_random_phase(300);

        // Highest base: existing frames now land one page further on, and the top
        // pool page falls outside the pool.
        wait_idle();
        write_pool_base('1);
        run_random_phase(250);

        // A base far away puts every stored frame outside the pool.
        wait_idle();
        write_pool_base(FRAME_W'({$urandom, $urandom}));
        run_random_phase(150);

        // A small shift makes walks land on other pool pages.
        wait_idle();
        write_pool_base(FRAME_W'(3));
        run_random_phase(250);

        wait_idle();
        write_pool_base('0);
        run_random_phase(320);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_of_run <= 1'b1;
        @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
